>>> design/cfe_pkg.sv
package cfe_pkg;

    localparam logic [7:0] SYNC_A = 8'hBA;
    localparam logic [7:0] SYNC_B = 8'hCE;
    localparam logic [7:0] LEN_HIGH = 8'h00;

    localparam int NUM_SLOTS = 11;
    localparam int HDR_SLOTS = 6;
    localparam int CKS_SLOTS = 4;
    localparam int SLOT_W = $clog2(NUM_SLOTS);

    typedef logic [SLOT_W-1:0] cfe_slot_t;
    typedef logic [NUM_SLOTS-1:0] cfe_mask_t;

    localparam cfe_slot_t SLOT_SYNC_A = SLOT_W'(0);
    localparam cfe_slot_t SLOT_SYNC_B = SLOT_W'(1);
    localparam cfe_slot_t SLOT_LEN_LO = SLOT_W'(2);
    localparam cfe_slot_t SLOT_LEN_HI = SLOT_W'(3);
    localparam cfe_slot_t SLOT_CLASS = SLOT_W'(4);
    localparam cfe_slot_t SLOT_MSG_ID = SLOT_W'(5);
    localparam cfe_slot_t SLOT_DATA = SLOT_W'(6);
    localparam cfe_slot_t SLOT_CKS_0 = SLOT_W'(7);
    localparam cfe_slot_t SLOT_CKS_1 = SLOT_W'(8);
    localparam cfe_slot_t SLOT_CKS_2 = SLOT_W'(9);
    localparam cfe_slot_t SLOT_CKS_3 = SLOT_W'(10);

    typedef struct packed {
        logic       first;
        logic [7:0] msg_class;
        logic [7:0] msg_id;
        logic [7:0] body_len;
        logic       has_byte;
        logic [7:0] payload_byte;
    } cfe_item_t;

    typedef struct packed {
        logic        hdr;
        logic [7:0]  len;
        logic [7:0]  cls;
        logic [7:0]  mid;
        logic        data;
        logic [7:0]  dbyte;
        logic        ovr;
        logic        cks;
        logic [31:0] sum;
    } cfe_desc_t;

endpackage

>>> design/cfe_item_if.sv
interface cfe_item_if;
    logic       valid;
    logic       ready;
    logic       first;
    logic [7:0] msg_class;
    logic [7:0] msg_id;
    logic [7:0] body_len;
    logic       has_byte;
    logic [7:0] payload_byte;

    modport source (
        output valid, first, msg_class, msg_id, body_len, has_byte, payload_byte,
        input  ready
    );
    modport sink (
        input  valid, first, msg_class, msg_id, body_len, has_byte, payload_byte,
        output ready
    );
endinterface

>>> design/cfe_frame_if.sv
interface cfe_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       overrun;

    modport source (
        output valid, frame_byte, frame_end, overrun,
        input  ready
    );
    modport sink (
        input  valid, frame_byte, frame_end, overrun,
        output ready
    );
endinterface

>>> design/cfe_core.sv
module cfe_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  cfe_pkg::cfe_item_t item,
    output cfe_pkg::cfe_desc_t desc
);
    import cfe_pkg::*;

    logic        active_reg, active_next;
    logic [7:0]  dlen_reg, dlen_next;
    logic [7:0]  idx_reg, idx_next;
    logic [31:0] sum_reg, sum_next;
    logic [23:0] gat_reg, gat_next;

    logic        act;
    logic [7:0]  dlen;
    logic [7:0]  idx;
    logic [23:0] gat;
    logic [31:0] base;
    logic        take;
    logic        cks;

    always_comb
    begin
        act  = item.first | active_reg;
        dlen = item.first ? item.body_len : dlen_reg;
        idx  = item.first ? 8'd0 : idx_reg;
        gat  = item.first ? 24'd0 : gat_reg;
        base = item.first ? {item.msg_id, item.msg_class, 8'h00, item.body_len} : sum_reg;
        take = item.has_byte & act & (idx < dlen);

        sum_next = base;
        gat_next = gat;
        idx_next = idx;
        if (take)
        begin
            idx_next = idx + 8'd1;
            case (idx[1:0])
                2'd0: gat_next = {gat[23:8], item.payload_byte};
                2'd1: gat_next = {gat[23:16], item.payload_byte, gat[7:0]};
                2'd2: gat_next = {item.payload_byte, gat[15:0]};
                default:
                begin
                    gat_next = 24'd0;
                    sum_next = base + {item.payload_byte, gat};
                end
            endcase
        end

        cks         = act & (idx_next == dlen);
        active_next = act & ~cks;
        dlen_next   = dlen;

        desc.hdr   = item.first;
        desc.len   = item.body_len;
        desc.cls   = item.msg_class;
        desc.mid   = item.msg_id;
        desc.data  = item.has_byte;
        desc.dbyte = take ? item.payload_byte : 8'd0;
        desc.ovr   = item.has_byte & ~take;
        desc.cks   = cks;
        desc.sum   = sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            dlen_reg   <= 8'd0;
            idx_reg    <= 8'd0;
            sum_reg    <= 32'd0;
            gat_reg    <= 24'd0;
        end
        else if (accept)
        begin
            active_reg <= active_next;
            dlen_reg   <= dlen_next;
            idx_reg    <= idx_next;
            sum_reg    <= sum_next;
            gat_reg    <= gat_next;
        end
    end

endmodule

>>> design/cfe_emit.sv
module cfe_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  cfe_pkg::cfe_desc_t desc,
    output logic               load_ok,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               out_end,
    output logic               out_ovr
);
    import cfe_pkg::*;

    cfe_desc_t desc_reg;
    cfe_mask_t pend_reg, pend_next;
    cfe_mask_t pend_after;
    cfe_mask_t lsb;
    cfe_mask_t load_mask;
    cfe_slot_t slot;
    logic      emit_ok;
    logic       ovalid_reg, ovalid_next;
    logic [7:0] obyte_reg, obyte_next;
    logic       oend_reg, oend_next;
    logic       oovr_reg, oovr_next;
    logic [7:0] sel_byte;

    always_comb
    begin
        load_mask = {{CKS_SLOTS{desc.cks}}, desc.data, {HDR_SLOTS{desc.hdr}}};
        lsb = pend_reg & (~pend_reg + cfe_mask_t'(1));
        slot = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (lsb[i])
            begin
                slot = cfe_slot_t'(i);
            end
        end

        unique case (slot)
            SLOT_SYNC_A: sel_byte = SYNC_A;
            SLOT_SYNC_B: sel_byte = SYNC_B;
            SLOT_LEN_LO: sel_byte = desc_reg.len;
            SLOT_LEN_HI: sel_byte = LEN_HIGH;
            SLOT_CLASS:  sel_byte = desc_reg.cls;
            SLOT_MSG_ID: sel_byte = desc_reg.mid;
            SLOT_DATA:   sel_byte = desc_reg.dbyte;
            SLOT_CKS_0:  sel_byte = desc_reg.sum[7:0];
            SLOT_CKS_1:  sel_byte = desc_reg.sum[15:8];
            SLOT_CKS_2:  sel_byte = desc_reg.sum[23:16];
            SLOT_CKS_3:  sel_byte = desc_reg.sum[31:24];
            default:     sel_byte = 8'd0;
        endcase

        emit_ok    = (pend_reg != '0) & (~ovalid_reg | out_ready);
        pend_after = emit_ok ? (pend_reg & ~lsb) : pend_reg;
        load_ok    = (pend_after == '0);
        pend_next  = load ? load_mask : pend_after;

        ovalid_next = ovalid_reg & ~out_ready;
        obyte_next  = obyte_reg;
        oend_next   = oend_reg;
        oovr_next   = oovr_reg;
        if (emit_ok)
        begin
            ovalid_next = 1'b1;
            obyte_next  = sel_byte;
            oend_next   = (slot == SLOT_CKS_3);
            oovr_next   = (slot == SLOT_DATA) & desc_reg.ovr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            desc_reg <= desc;
        end
        obyte_reg <= obyte_next;
        oend_reg  <= oend_next;
        oovr_reg  <= oovr_next;
    end

    assign out_valid = ovalid_reg;
    assign out_byte  = obyte_reg;
    assign out_end   = oend_reg;
    assign out_ovr   = oovr_reg;

endmodule

>>> design/cas_frame_encoder_unit.sv
// Binary command frame encoder. The pkt channel takes one item per payload byte;
// the item that starts a packet has first set and carries class, message id and
// payload length. A packet with an empty payload is a single item without a byte.
// The frame channel gives one frame byte per item: sync bytes, length, class,
// message id, the payload, and a four-byte little-endian checksum, with
// frame_end set on the last checksum byte. A byte beyond the declared length, or
// outside a packet, gives one item with overrun set and frame_byte zero.
// An accepted input item is turned into a burst descriptor in the same cycle; the
// descriptor and its pending-byte mask are registered, and each frame byte passes
// through the output register before it is valid on the frame channel.
// A payload item in the middle of a packet gives one frame byte, so the block
// sustains one item per cycle unless stalled. A header item gives six bytes, one
// more when it carries a byte and four more when it also closes the packet; the
// last payload item gives five. pkt.ready stays low until the burst is down to
// its last byte; the single output port of the byte serializer sets that rate.
// Reset clears the packet state and empties the frame channel. When the receiver
// stalls, the frame byte holds, one more input item can be taken in behind it,
// and pkt.ready then stays low until the stall ends.
module cas_frame_encoder_unit (
    input logic         clk,
    input logic         rst_n,
    cfe_item_if.sink    pkt,
    cfe_frame_if.source frame
);
    import cfe_pkg::*;

    cfe_item_t item;
    cfe_desc_t desc;
    logic      load_ok;
    logic      accept;

    assign item = '{
        first:        pkt.first,
        msg_class:    pkt.msg_class,
        msg_id:       pkt.msg_id,
        body_len:     pkt.body_len,
        has_byte:     pkt.has_byte,
        payload_byte: pkt.payload_byte
    };

    assign accept    = pkt.valid & load_ok;
    assign pkt.ready = load_ok;

    cfe_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .desc   (desc)
    );

    cfe_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .desc      (desc),
        .load_ok   (load_ok),
        .out_valid (frame.valid),
        .out_ready (frame.ready),
        .out_byte  (frame.frame_byte),
        .out_end   (frame.frame_end),
        .out_ovr   (frame.overrun)
    );

endmodule

>>> design/cfe_checker.sv
module cfe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] frame_byte,
    input logic       frame_end,
    input logic       overrun
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("frame item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(frame_byte) && $stable(frame_end)
            && $stable(overrun))
        else $error("stalled frame item changed");

    a_overrun_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overrun |-> frame_byte == 8'd0 && !frame_end)
        else $error("overrun item carries data or frame end");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("frame channel not empty after reset");

endmodule

bind cas_frame_encoder_unit cfe_checker u_cfe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (frame.valid),
    .out_ready  (frame.ready),
    .frame_byte (frame.frame_byte),
    .frame_end  (frame.frame_end),
    .overrun    (frame.overrun)
);

>>> tb/testbench.sv
module testbench;
    import cfe_pkg::*;

    typedef struct packed {
        logic [7:0] fbyte;
        logic       fend;
        logic       ovr;
    } frame_out_t;

    localparam int ITEM_TARGET = 280;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES = 150;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic src_valid = 1'b0;
    cfe_item_t src_item = '0;
    logic sink_ready = 1'b0;

    cfe_item_if pkt_if ();
    cfe_frame_if frame_if ();

    assign pkt_if.valid = src_valid;
    assign pkt_if.first = src_item.first;
    assign pkt_if.msg_class = src_item.msg_class;
    assign pkt_if.msg_id = src_item.msg_id;
    assign pkt_if.body_len = src_item.body_len;
    assign pkt_if.has_byte = src_item.has_byte;
    assign pkt_if.payload_byte = src_item.payload_byte;
    assign frame_if.ready = sink_ready;

    cas_frame_encoder_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt_if),
        .frame (frame_if)
    );

    cfe_item_t pending[$];
    frame_out_t frame_due[$];

    logic pk_active = 1'b0;
    logic [7:0] pk_len = '0;
    logic [7:0] pk_index = '0;
    logic [31:0] pk_sum = '0;
    logic [23:0] pk_gather = '0;

    int errors = 0;
    int stim_count = 0;
    int items_in = 0;
    int items_sent = 0;
    int bytes_out = 0;
    int bytes_seen = 0;
    int idle_cycles = 0;
    int src_gap = 0;
    int sink_gap = 0;
    int sink_hold = 0;
    logic src_burst = 1'b0;
    logic sink_burst = 1'b0;

    always #5 clk = ~clk;

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    function automatic void due(logic [7:0] b, logic e, logic o);
        frame_due.push_back({b, e, o});
    endfunction

    function automatic void encode_item(cfe_item_t it);
        int pos;
        if (it.first)
        begin
            due(SYNC_A, 1'b0, 1'b0);
            due(SYNC_B, 1'b0, 1'b0);
            due(it.body_len, 1'b0, 1'b0);
            due(LEN_HIGH, 1'b0, 1'b0);
            due(it.msg_class, 1'b0, 1'b0);
            due(it.msg_id, 1'b0, 1'b0);
            pk_active = 1'b1;
            pk_len = it.body_len;
            pk_index = '0;
            pk_gather = '0;
            pk_sum = {it.msg_id, 24'h0} + {8'h0, it.msg_class, 16'h0}
                + {24'h0, it.body_len};
        end
        if (it.has_byte)
        begin
            if (pk_active && pk_index < pk_len)
            begin
                pos = int'(pk_index[1:0]);
                due(it.payload_byte, 1'b0, 1'b0);
                if (pos == 3)
                begin
                    pk_sum = pk_sum + {it.payload_byte, pk_gather};
                    pk_gather = '0;
                end
                else
                begin
                    pk_gather = pk_gather | (24'(it.payload_byte) << (8 * pos));
                end
                pk_index = pk_index + 8'd1;
            end
            else
            begin
                due(8'h00, 1'b0, 1'b1);
            end
        end
        if (pk_active && pk_index == pk_len)
        begin
            due(pk_sum[7:0], 1'b0, 1'b0);
            due(pk_sum[15:8], 1'b0, 1'b0);
            due(pk_sum[23:16], 1'b0, 1'b0);
            due(pk_sum[31:24], 1'b1, 1'b0);
            pk_active = 1'b0;
        end
    endfunction

    function automatic void queue_item(logic f, logic [7:0] c, logic [7:0] m,
                                       logic [7:0] l, logic h, logic [7:0] b);
        cfe_item_t it;
        it.first = f;
        it.msg_class = c;
        it.msg_id = m;
        it.body_len = l;
        it.has_byte = h;
        it.payload_byte = b;
        pending.push_back(it);
        if (f || h)
            stim_count++;
    endfunction

    // The header item carries the first payload byte when lead is set and sent is nonzero.
    function automatic void queue_packet(logic [7:0] len, int sent, logic lead);
        int rest;
        rest = sent;
        if (lead && rest > 0)
            rest--;
        queue_item(1'b1, rnd8(), rnd8(), len, lead && sent > 0, rnd8());
        for (int i = 0; i < rest; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                queue_item(1'b0, rnd8(), rnd8(), rnd8(), 1'b0, rnd8());
            queue_item(1'b0, rnd8(), rnd8(), rnd8(), 1'b1, rnd8());
        end
    endfunction

    always @(negedge clk)
    begin
        if (rst_n && (!src_valid || items_in == items_sent))
        begin
            if (src_gap > 0)
            begin
                src_valid <= 1'b0;
                src_gap = src_gap - 1;
            end
            else if (pending.size() > 0)
            begin
                src_item <= pending.pop_front();
                src_valid <= 1'b1;
                items_sent = items_sent + 1;
                if ($urandom_range(0, 39) == 0)
                    src_burst = !src_burst;
                src_gap = src_burst ? 0 : $urandom_range(0, 10);
            end
            else
            begin
                src_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (bytes_out != bytes_seen)
            begin
                bytes_seen = bytes_out;
                if ($urandom_range(0, 39) == 0)
                    sink_burst = !sink_burst;
                sink_gap = sink_burst ? 0 : $urandom_range(0, 10);
                if (bytes_seen % 300 == 40)
                    sink_hold = HOLD_CYCLES;
            end
            if (sink_hold > 0)
            begin
                sink_ready <= 1'b0;
                sink_hold = sink_hold - 1;
            end
            else if (sink_gap > 0)
            begin
                sink_ready <= 1'b0;
                sink_gap = sink_gap - 1;
            end
            else
            begin
                sink_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        frame_out_t got;
        frame_out_t want;
        logic moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (src_valid && pkt_if.ready)
            begin
                encode_item(src_item);
                items_in++;
                moved = 1'b1;
            end
            if (frame_if.valid && sink_ready)
            begin
                got = {frame_if.frame_byte, frame_if.frame_end, frame_if.overrun};
                if (frame_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected frame item, got byte=%02h end=%0b overrun=%0b",
                             $time, got.fbyte, got.fend, got.ovr);
                end
                else
                begin
                    want = frame_due.pop_front();
                    if (got.fbyte !== want.fbyte || got.fend !== want.fend
                        || got.ovr !== want.ovr)
                    begin
                        errors++;
                        $display("%0t: frame mismatch, expected %02h %0b %0b, got %02h %0b %0b",
                                 $time, want.fbyte, want.fend, want.ovr,
                                 got.fbyte, got.fend, got.ovr);
                    end
                end
                bytes_out++;
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        int sel;
        logic [7:0] len;

        queue_item(1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF);
        queue_item(1'b1, 8'hFF, 8'hFF, 8'h00, 1'b0, 8'h00);
        queue_item(1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 8'hAA);
        queue_item(1'b1, 8'h00, 8'h80, 8'h05, 1'b1, 8'hFF);
        queue_item(1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
        queue_item(1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
        queue_item(1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
        queue_item(1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 8'h01);
        queue_item(1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'hFF);
        queue_item(1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00);
        queue_item(1'b1, 8'h55, 8'hAA, 8'h04, 1'b0, 8'h00);
        queue_item(1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00);
        queue_item(1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00);
        queue_item(1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00);
        queue_item(1'b1, 8'h01, 8'h02, 8'h01, 1'b1, 8'h7F);
        queue_item(1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
        for (int i = 1; i < 255; i++)
            queue_item(1'b0, rnd8(), rnd8(), rnd8(), 1'b1, rnd8());

        while (stim_count < ITEM_TARGET)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
            begin
                len = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(13, 40))
                                                  : 8'($urandom_range(0, 12));
                queue_packet(len, int'(len), $urandom_range(0, 3) != 0);
            end
            else if (sel == 7)
            begin
                len = 8'($urandom_range(2, 20));
                queue_packet(len, $urandom_range(0, int'(len) - 1), 1'($urandom_range(0, 1)));
            end
            else if (sel == 8)
            begin
                queue_item(1'b0, rnd8(), rnd8(), rnd8(), 1'b1, rnd8());
            end
            else
            begin
                queue_item(1'b1, rnd8(), rnd8(), 8'h00, 1'($urandom_range(0, 1)), rnd8());
            end
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || src_valid || frame_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
design/cfe_pkg.sv
design/cfe_item_if.sv
design/cfe_frame_if.sv
design/cfe_core.sv
design/cfe_emit.sv
design/cas_frame_encoder_unit.sv
design/cfe_checker.sv
tb/testbench.sv
